@@ sv/weighted_least_conn_select_defines.svh @@
// Assertion macros shared by the weighted least-connections selector.
`ifndef WEIGHTED_LEAST_CONN_SELECT_DEFINES_SVH
`define WEIGHTED_LEAST_CONN_SELECT_DEFINES_SVH

`ifndef SYNTHESIS

`define WLCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define WLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WLCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define WLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/wlcs_pkg.sv @@
// Types, constants and helpers of the weighted least-connections selector.
package wlcs_pkg;

    localparam int BACKEND_COUNT_DEF = 64;
    localparam int ENTRY_CAP         = 64;
    localparam int ACT_W             = 2;
    localparam int IDX_W             = 6;
    localparam int CNT_CFG_W         = 7;
    localparam int WEIGHT_W          = 16;
    localparam int CONN_W            = 32;
    localparam int STATUS_W          = 2;
    localparam int PROD_W            = WEIGHT_W + CONN_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_PICK       = 2'd0,
        ACT_RELEASE    = 2'd1,
        ACT_SET_WEIGHT = 2'd2,
        ACT_QUERY      = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_ELIGIBLE  = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_MUL,
        S_SCAN_CMP,
        S_PICK_WR,
        S_ACCESS,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [CONN_W-1:0]   conns;
    } entry_t;

    function automatic logic [CONN_W-1:0] sat_inc(input logic [CONN_W-1:0] value);
        sat_inc = (value == {CONN_W{1'b1}}) ? value : value + {{(CONN_W-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [CONN_W-1:0] floor_dec(input logic [CONN_W-1:0] value);
        floor_dec = (value == '0) ? value : value - {{(CONN_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

@@ sv/wlcs_entry_mem.sv @@
// Backend entry memory (weight and count) with per-entry valid bits.
module wlcs_entry_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output wlcs_pkg::entry_t    rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  wlcs_pkg::entry_t    wr_data
);
    import wlcs_pkg::*;

    entry_t             mem [0:DEPTH-1];
    entry_t             rd_q_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;

    // Entries never written read as zero: weight zero, count zero.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

@@ sv/wlcs_ratio_cmp.sv @@
// Cross-multiplying load comparator: candidate is better when cc*wb < cb*wc.
module wlcs_ratio_cmp (
    input  logic                clk,
    input  logic                load,
    input  wlcs_pkg::entry_t    cand,
    input  wlcs_pkg::entry_t    best,
    output logic                less
);
    import wlcs_pkg::*;

    logic [PROD_W-1:0] prod_cand_reg;
    logic [PROD_W-1:0] prod_best_reg;

    always_ff @(posedge clk) begin
        if (load) begin
            prod_cand_reg <= {{WEIGHT_W{1'b0}}, cand.conns} * {{CONN_W{1'b0}}, best.weight};
            prod_best_reg <= {{WEIGHT_W{1'b0}}, best.conns} * {{CONN_W{1'b0}}, cand.weight};
        end
    end

    assign less = prod_cand_reg < prod_best_reg;

endmodule

@@ sv/weighted_least_conn_select.sv @@
// Top level of the weighted least-connections backend selector.
//
//  Channel  Handshake               Payload
//  cfg      cfg_valid / cfg_ready   active_backends
//  in       in_valid / in_ready     action, backend_index, new_weight
//  out      out_valid / out_ready   chosen_backend, status, conns_after
//
// A pick scans the N active entries; per entry it takes the memory read and
// forms the two products, then compares them. If an eligible entry was
// found, the chosen count is written back. Release, set weight and query
// pass through read, modify and write, and result. A pick with no active
// entries or an access outside the active range goes straight to the
// result. One transaction is worked on at a time. Reset clears all weights
// and counts through per-entry valid bits, so no clearing pass is needed. A
// stalled output holds the next result in the result stage.
`include "weighted_least_conn_select_defines.svh"

module weighted_least_conn_select #(
    parameter int BACKEND_COUNT = wlcs_pkg::BACKEND_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wlcs_pkg::CNT_CFG_W-1:0]      active_backends,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [wlcs_pkg::ACT_W-1:0]          action,
    input  logic [wlcs_pkg::IDX_W-1:0]          backend_index,
    input  logic [wlcs_pkg::WEIGHT_W-1:0]       new_weight,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wlcs_pkg::IDX_W-1:0]          chosen_backend,
    output logic [wlcs_pkg::STATUS_W-1:0]       status,
    output logic [wlcs_pkg::CONN_W-1:0]         conns_after
);
    import wlcs_pkg::*;

    localparam int MEM_DEPTH = (BACKEND_COUNT < ENTRY_CAP) ? BACKEND_COUNT : ENTRY_CAP;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [CNT_CFG_W-1:0] DEPTH_N = CNT_CFG_W'(MEM_DEPTH);

    state_t                 state_reg, state_next;
    logic [CNT_CFG_W-1:0]   active_reg;
    action_t                act_reg, act_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [WEIGHT_W-1:0]    wt_reg, wt_next;
    logic [IDX_W-1:0]       cand_pos_reg, cand_pos_next;
    entry_t                 cand_reg, cand_next;
    entry_t                 best_reg, best_next;
    logic [IDX_W-1:0]       best_pos_reg, best_pos_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;
    status_t                res_status_reg, res_status_next;
    logic [CONN_W-1:0]      res_conns_reg, res_conns_next;
    logic                   out_valid_reg;
    logic [IDX_W-1:0]       chosen_backend_reg;
    status_t                status_reg;
    logic [CONN_W-1:0]      conns_after_reg;

    logic [CNT_CFG_W-1:0]   n_eff;
    logic                   in_range;
    logic                   last_cand;
    logic                   take_cand;
    logic                   out_load;

    logic                   mem_rd_en;
    logic [IDX_W-1:0]       mem_rd_idx;
    entry_t                 mem_rd_data;
    logic                   mem_wr_en;
    logic [IDX_W-1:0]       mem_wr_idx;
    entry_t                 mem_wr_data;
    logic                   cmp_load;
    logic                   cmp_less;

    wlcs_entry_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_idx[ADDR_W-1:0]),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_idx[ADDR_W-1:0]),
        .wr_data (mem_wr_data)
    );

    wlcs_ratio_cmp u_cmp (
        .clk  (clk),
        .load (cmp_load),
        .cand (mem_rd_data),
        .best (best_reg),
        .less (cmp_less)
    );

    assign n_eff     = (active_reg > DEPTH_N) ? DEPTH_N : active_reg;
    assign in_range  = {1'b0, backend_index} < n_eff;
    assign last_cand = ({1'b0, cand_pos_reg} + CNT_CFG_W'(1)) == n_eff;
    assign take_cand = (cand_reg.weight != '0) && (!found_reg || cmp_less);
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            found_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            found_reg <= found_next;
            if (cfg_valid && cfg_ready) begin
                active_reg <= active_backends;
            end
        end
    end

    always_ff @(posedge clk) begin
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        wt_reg         <= wt_next;
        cand_pos_reg   <= cand_pos_next;
        cand_reg       <= cand_next;
        best_reg       <= best_next;
        best_pos_reg   <= best_pos_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        res_conns_reg  <= res_conns_next;
    end

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        idx_next        = idx_reg;
        wt_next         = wt_reg;
        cand_pos_next   = cand_pos_reg;
        cand_next       = cand_reg;
        best_next       = best_reg;
        best_pos_next   = best_pos_reg;
        found_next      = found_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        res_conns_next  = res_conns_reg;
        mem_rd_en       = 1'b0;
        mem_rd_idx      = '0;
        mem_wr_en       = 1'b0;
        mem_wr_idx      = '0;
        mem_wr_data     = '0;
        cmp_load        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    act_next = action_t'(action);
                    idx_next = backend_index;
                    wt_next  = new_weight;
                    if (action_t'(action) == ACT_PICK) begin
                        if (n_eff == '0) begin
                            res_idx_next    = '0;
                            res_status_next = ST_NO_ELIGIBLE;
                            res_conns_next  = '0;
                            state_next      = S_RESP;
                        end
                        else begin
                            mem_rd_en     = 1'b1;
                            mem_rd_idx    = '0;
                            cand_pos_next = '0;
                            found_next    = 1'b0;
                            best_next     = '0;
                            state_next    = S_SCAN_MUL;
                        end
                    end
                    else if (!in_range) begin
                        res_idx_next    = backend_index;
                        res_status_next = ST_OUT_OF_RANGE;
                        res_conns_next  = '0;
                        state_next      = S_RESP;
                    end
                    else begin
                        mem_rd_en  = 1'b1;
                        mem_rd_idx = backend_index;
                        state_next = S_ACCESS;
                    end
                end
            end
            S_SCAN_MUL: begin
                cmp_load  = 1'b1;
                cand_next = mem_rd_data;
                if (!last_cand) begin
                    mem_rd_en  = 1'b1;
                    mem_rd_idx = cand_pos_reg + IDX_W'(1);
                end
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (take_cand) begin
                    best_next     = cand_reg;
                    best_pos_next = cand_pos_reg;
                    found_next    = 1'b1;
                end
                if (last_cand) begin
                    if (take_cand || found_reg) begin
                        state_next = S_PICK_WR;
                    end
                    else begin
                        res_idx_next    = '0;
                        res_status_next = ST_NO_ELIGIBLE;
                        res_conns_next  = '0;
                        state_next      = S_RESP;
                    end
                end
                else begin
                    cand_pos_next = cand_pos_reg + IDX_W'(1);
                    state_next    = S_SCAN_MUL;
                end
            end
            S_PICK_WR: begin
                mem_wr_en          = 1'b1;
                mem_wr_idx         = best_pos_reg;
                mem_wr_data.weight = best_reg.weight;
                mem_wr_data.conns  = sat_inc(best_reg.conns);
                res_idx_next       = best_pos_reg;
                res_status_next    = ST_OK;
                res_conns_next     = sat_inc(best_reg.conns);
                state_next         = S_RESP;
            end
            S_ACCESS: begin
                mem_wr_idx      = idx_reg;
                mem_wr_data     = mem_rd_data;
                res_idx_next    = idx_reg;
                res_status_next = ST_OK;
                res_conns_next  = mem_rd_data.conns;
                case (act_reg)
                    ACT_RELEASE: begin
                        mem_wr_en         = 1'b1;
                        mem_wr_data.conns = floor_dec(mem_rd_data.conns);
                        res_conns_next    = floor_dec(mem_rd_data.conns);
                    end
                    ACT_SET_WEIGHT: begin
                        mem_wr_en          = 1'b1;
                        mem_wr_data.weight = wt_reg;
                    end
                    default: begin
                        mem_wr_en = 1'b0;
                    end
                endcase
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            chosen_backend_reg <= res_idx_reg;
            status_reg         <= res_status_reg;
            conns_after_reg    <= res_conns_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign chosen_backend = chosen_backend_reg;
    assign status         = status_reg;
    assign conns_after    = conns_after_reg;

    // A successful result always names an entry inside the active range.
    `WLCS_ASSERT_SAME(a_ok_in_range, clk, rst_n,
        out_valid_reg && (status_reg == ST_OK), {1'b0, chosen_backend_reg} < n_eff,
        "OK result outside the active range")

    // The scan never steps past the last active entry.
    `WLCS_ASSERT_SAME(a_scan_in_range, clk, rst_n,
        (state_reg == S_SCAN_MUL) || (state_reg == S_SCAN_CMP), {1'b0, cand_pos_reg} < n_eff,
        "Scan position outside the active range")

    // The write-back of a pick only follows an eligible winner.
    `WLCS_ASSERT_NEXT(a_pick_has_winner, clk, rst_n,
        (state_reg == S_SCAN_CMP) && (state_next == S_PICK_WR),
        found_reg && (best_reg.weight != '0),
        "Pick write-back without an eligible winner")

endmodule
